FILE: hdl/triangle_adjacency_finder_defines.svh
// Assertion macros for the triangle adjacency finder.
// Included by the top level; depends on nothing else.
`ifndef TRIANGLE_ADJACENCY_FINDER_DEFINES_SVH
`define TRIANGLE_ADJACENCY_FINDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TAF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("triangle adjacency finder check failed");

// Next-cycle implication, disabled while reset is asserted.
`define TAF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("triangle adjacency finder check failed");

`endif

FILE: hdl/tri_adj_pkg.sv
// Shared types and constants for the triangle adjacency finder.
// Used by the front end, back end and top level; depends on nothing.
package tri_adj_pkg;

  localparam int SLOT_W  = 10;
  localparam int VTX_W   = 16;
  localparam int TRI_W   = 3 * VTX_W;
  localparam int NCNT_W  = 2;
  localparam int NSLOTS  = 3;

  typedef enum logic {
    OP_STORE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_e;

  typedef struct packed {
    opcode_e             opcode;
    logic [SLOT_W-1:0]   slot;
    logic [VTX_W-1:0]    vertex_a;
    logic [VTX_W-1:0]    vertex_b;
    logic [VTX_W-1:0]    vertex_c;
  } cmd_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot_out;
    logic [NCNT_W-1:0]   neighbour_count;
    logic [SLOT_W-1:0]   neighbour_first;
    logic [SLOT_W-1:0]   neighbour_second;
    logic [SLOT_W-1:0]   neighbour_third;
    logic                error;
  } result_t;

  typedef struct packed {
    logic    valid;
    cmd_in_t cmd;
  } head_t;

endpackage

FILE: hdl/tri_adj_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Holds the triangle table; depends on nothing.
module tri_adj_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/tri_adj_front.sv
// Front end of the triangle adjacency finder: accepts command words into a
// two-entry queue. Depends on tri_adj_pkg.
module tri_adj_front (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  tri_adj_pkg::cmd_in_t cmd_i,
  output tri_adj_pkg::head_t   head_o,
  input  logic                 pop_i
);

  logic [1:0]           cnt_q, cnt_d;
  logic                 wr_ptr_q, wr_ptr_d;
  logic                 rd_ptr_q, rd_ptr_d;
  tri_adj_pkg::cmd_in_t ent_q [2];
  logic                 push;
  logic                 pop;

  assign busy = (cnt_q == 2'd2);
  assign push = start && !busy;
  assign pop  = pop_i && (cnt_q != 2'd0);

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.cmd   = ent_q[rd_ptr_q];

  always_comb begin
    cnt_d    = cnt_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = !wr_ptr_q;
    end
    if (pop) begin
      rd_ptr_d = !rd_ptr_q;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

FILE: hdl/tri_adj_back.sv
// Back end of the triangle adjacency finder: appends triangles and scans the
// table for shared-edge neighbours. Depends on tri_adj_pkg and tri_adj_ram.
module tri_adj_back #(
  parameter int MAX_TRIANGLES  = 1024,
  parameter int MAX_NEIGHBOURS = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  tri_adj_pkg::head_t   head_i,
  output logic                 pop_o,
  output logic                 done_o,
  output tri_adj_pkg::result_t result_o
);

  localparam int AW   = $clog2(MAX_TRIANGLES);
  localparam int CW   = $clog2(MAX_TRIANGLES + 1);
  localparam int CMPW = (CW > tri_adj_pkg::SLOT_W) ? CW : tri_adj_pkg::SLOT_W;
  localparam int SW   = tri_adj_pkg::SLOT_W;
  localparam int VW   = tri_adj_pkg::VTX_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_REF  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;

  logic [1:0]                      state_q, state_d;
  logic [CW-1:0]                   count_q, count_d;
  logic [CW-1:0]                   iss_q, iss_d;
  logic [tri_adj_pkg::TRI_W-1:0]   ref_q, ref_d;
  logic [SW-1:0]                   found_q [tri_adj_pkg::NSLOTS];
  logic [SW-1:0]                   found_d [tri_adj_pkg::NSLOTS];
  logic [tri_adj_pkg::NCNT_W-1:0]  nfound_q, nfound_d, nf_next;
  logic [SW-1:0]                   qslot_q, qslot_d;
  tri_adj_pkg::result_t            res_q, res_d;
  logic                            done_q, done_d;

  logic                            we;
  logic [AW-1:0]                   raddr;
  logic [tri_adj_pkg::TRI_W-1:0]   rdata;
  logic [tri_adj_pkg::TRI_W-1:0]   wdata;
  logic                            full;
  logic [CMPW-1:0]                 slot_ext;
  logic [CMPW-1:0]                 count_ext;
  logic [CMPW-1:0]                 cmp_ext;
  logic                            matched;

  function automatic logic [1:0] count_hits(
    input logic [tri_adj_pkg::TRI_W-1:0] q,
    input logic [tri_adj_pkg::TRI_W-1:0] c
  );
    logic [1:0] hits;
    logic [VW-1:0] qv;
    hits = 2'd0;
    for (int i = 0; i < 3; i++) begin
      qv = q[i*VW +: VW];
      if (qv == c[0 +: VW] || qv == c[VW +: VW] || qv == c[2*VW +: VW]) begin
        hits = hits + 2'd1;
      end
    end
    return hits;
  endfunction

  assign full      = (count_q == CW'(MAX_TRIANGLES));
  assign slot_ext  = CMPW'(head_i.cmd.slot);
  assign count_ext = CMPW'(count_q);
  assign cmp_ext   = CMPW'(iss_q - CW'(1));
  assign wdata     = {head_i.cmd.vertex_c, head_i.cmd.vertex_b, head_i.cmd.vertex_a};
  assign matched   = (count_hits(ref_q, rdata) == 2'd2);
  assign nf_next   = nfound_q + tri_adj_pkg::NCNT_W'(matched);

  assign we    = (state_q == S_IDLE) && head_i.valid &&
                 (head_i.cmd.opcode == tri_adj_pkg::OP_STORE) && !full;
  assign pop_o = (state_q == S_IDLE) && head_i.valid;

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    iss_d    = iss_q;
    ref_d    = ref_q;
    found_d  = found_q;
    nfound_d = nfound_q;
    qslot_d  = qslot_q;
    res_d    = res_q;
    done_d   = 1'b0;
    raddr    = slot_ext[AW-1:0];
    case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          res_d = '0;
          if (head_i.cmd.opcode == tri_adj_pkg::OP_STORE) begin
            done_d = 1'b1;
            if (full) begin
              res_d.error = 1'b1;
            end else begin
              res_d.slot_out = count_ext[SW-1:0];
              count_d        = count_q + CW'(1);
            end
          end else if (slot_ext >= count_ext) begin
            done_d         = 1'b1;
            res_d.slot_out = head_i.cmd.slot;
            res_d.error    = 1'b1;
          end else begin
            qslot_d  = head_i.cmd.slot;
            nfound_d = '0;
            for (int k = 0; k < tri_adj_pkg::NSLOTS; k++) begin
              found_d[k] = '0;
            end
            state_d = S_REF;
          end
        end
      end
      S_REF: begin
        ref_d   = rdata;
        raddr   = '0;
        iss_d   = CW'(1);
        state_d = S_SCAN;
      end
      S_SCAN: begin
        raddr = iss_q[AW-1:0];
        if (matched) begin
          found_d[nfound_q] = cmp_ext[SW-1:0];
          nfound_d          = nf_next;
        end
        if ((matched && nf_next == tri_adj_pkg::NCNT_W'(MAX_NEIGHBOURS)) ||
            iss_q == count_q) begin
          done_d                 = 1'b1;
          res_d.slot_out         = qslot_q;
          res_d.neighbour_count  = nf_next;
          res_d.neighbour_first  = found_d[0];
          res_d.neighbour_second = found_d[1];
          res_d.neighbour_third  = found_d[2];
          res_d.error            = 1'b0;
          state_d                = S_IDLE;
        end else begin
          iss_d = iss_q + CW'(1);
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    iss_q    <= iss_d;
    ref_q    <= ref_d;
    found_q  <= found_d;
    nfound_q <= nfound_d;
    qslot_q  <= qslot_d;
    res_q    <= res_d;
  end

  tri_adj_ram #(
    .WIDTH (tri_adj_pkg::TRI_W),
    .DEPTH (MAX_TRIANGLES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

FILE: hdl/triangle_adjacency_finder.sv
// Top level of the triangle adjacency finder: front queue plus back end.
// Depends on tri_adj_pkg, tri_adj_front, tri_adj_back and the defines header.
//
// A command word is taken on a rising edge where start is high and busy is
// low; busy rises only when the two-entry command queue is full. A store
// word appends its triangle to the next free slot and reports that slot, or
// an error when the table is full. A query word reports up to MAX_NEIGHBOURS
// stored triangles sharing exactly two vertex indices with the queried one,
// lowest slots first, or an error when the slot was never stored.
// Each word yields one result word, shown on result_o for a single cycle
// while done_o is high; the receiver cannot stall it.
// A store is answered from the idle state via the result register. A query
// reads the queried triangle in a reference state, then scans the stored
// triangles one table entry per cycle through the table's single read port,
// ending early once enough neighbours are found. Reset clears the queue and
// the stored count; the table itself is not cleared and is ready at once.
`include "triangle_adjacency_finder_defines.svh"

module triangle_adjacency_finder #(
  parameter int MAX_TRIANGLES  = 1024,
  parameter int MAX_NEIGHBOURS = 3
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  tri_adj_pkg::cmd_in_t cmd_i,
  output logic                 done_o,
  output tri_adj_pkg::result_t result_o
);

  tri_adj_pkg::head_t head;
  logic               pop;

  tri_adj_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_i  (cmd_i),
    .head_o (head),
    .pop_i  (pop)
  );

  tri_adj_back #(
    .MAX_TRIANGLES  (MAX_TRIANGLES),
    .MAX_NEIGHBOURS (MAX_NEIGHBOURS)
  ) u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .pop_o    (pop),
    .done_o   (done_o),
    .result_o (result_o)
  );

  `TAF_ASSERT_NOW(a_busy_needs_head, clk_i, rst_ni, busy, head.valid)
  `TAF_ASSERT_NOW(a_count_bound, clk_i, rst_ni, done_o,
                  result_o.neighbour_count <= MAX_NEIGHBOURS)
  `TAF_ASSERT_NOW(a_ascending, clk_i, rst_ni,
                  done_o && result_o.neighbour_count >= 2'd2,
                  result_o.neighbour_first < result_o.neighbour_second)
  `TAF_ASSERT_NEXT(a_accept_fills, clk_i, rst_ni, start && !busy, head.valid)

endmodule
